// ----- hw/rtl/acl_pkg.sv -----
// Shared types and constants for the access rights table.
`default_nettype none
package acl_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [1:0] MODE_GRANT  = 2'd0;
  localparam logic [1:0] MODE_DENY   = 2'd1;
  localparam logic [1:0] MODE_REVOKE = 2'd2;
  localparam logic [1:0] MODE_CHECK  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] allow;
    logic [31:0] deny;
  } acl_entry_t;

  localparam int ENTRY_W = $bits(acl_entry_t);

  typedef struct packed {
    logic start;
    logic step;
  } acl_cmd_t;

  typedef struct packed {
    logic done;
  } acl_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/acl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module acl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/acl_ctrl.sv -----
// Controller: accepts an item, sequences the table scan, owns output valid.
`default_nettype none
module acl_ctrl import acl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output acl_cmd_t      cmd,
  input  wire acl_sts_t sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic finish;

  assign in_ready  = (state == S_IDLE);
  assign cmd.start = in_valid && in_ready;
  assign cmd.step  = (state == S_SCAN) && !(out_valid && !out_ready);
  assign finish    = cmd.step && sts.done;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/acl_dp.sv -----
// Datapath: command registers, entry scan, table update and result register.
`default_nettype none
module acl_dp import acl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire acl_cmd_t    cmd,
  output acl_sts_t         sts,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] key,
  input  wire logic [31:0] rights,
  output logic      [1:0]  status,
  output logic             granted
);

  logic [1:0]       mode_q;
  logic [63:0]      key_q;
  logic [31:0]      rights_q;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] used;
  logic             pend;
  logic [IDX_W-1:0] pidx;

  acl_entry_t       rd_ent;
  acl_entry_t       wr_ent;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             scan_more;
  logic             match;
  logic             miss;
  logic             finish;
  logic             full;
  logic [1:0]       status_next;
  logic             granted_next;
  logic             used_inc;

  assign scan_more = cnt < used;
  assign match     = pend && (rd_ent.key == key_q);
  assign miss      = !match && !scan_more;
  assign sts.done  = match || miss;
  assign finish    = cmd.step && sts.done;
  assign full      = (used == CNT_W'(ENTRIES));

  acl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wr_ent),
    .re   (cmd.step && scan_more),
    .raddr(cnt[IDX_W-1:0]),
    .rdata(rd_ent)
  );

  always_comb begin
    wr_ent       = rd_ent;
    we           = 1'b0;
    waddr        = pidx;
    status_next  = ST_OK;
    granted_next = 1'b0;
    used_inc     = 1'b0;
    if (match) begin
      unique case (mode_q)
        MODE_GRANT:  begin wr_ent.allow = rd_ent.allow | rights_q;  we = finish; end
        MODE_DENY:   begin wr_ent.deny  = rd_ent.deny | rights_q;   we = finish; end
        MODE_REVOKE: begin wr_ent.allow = rd_ent.allow & ~rights_q; we = finish; end
        MODE_CHECK:  begin
          granted_next = ((rd_ent.allow & rights_q) == rights_q) &&
                         ((rd_ent.deny & rights_q) == 32'd0);
        end
        default: ;
      endcase
    end else begin
      priority if (mode_q != MODE_GRANT) begin
        status_next = ST_NOT_FOUND;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        wr_ent.key   = key_q;
        wr_ent.allow = rights_q;
        wr_ent.deny  = 32'd0;
        waddr        = used[IDX_W-1:0];
        we           = finish;
        used_inc     = finish;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q   <= mode;
      key_q    <= key;
      rights_q <= rights;
    end
    if (cmd.step) begin
      pidx <= cnt[IDX_W-1:0];
    end
    if (finish) begin
      status  <= status_next;
      granted <= granted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
      used <= '0;
    end else begin
      if (cmd.start) begin
        cnt  <= '0;
        pend <= 1'b0;
      end else if (cmd.step) begin
        if (scan_more) begin
          cnt <= cnt + 1'b1;
        end
        pend <= scan_more;
      end
      if (used_inc) begin
        used <= used + 1'b1;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(ENTRIES))
    else $error("entry count above table depth");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= used)
    else $error("scan index past used entries");

  a_used_grow: assert property (@(posedge clk) disable iff (rst)
    (used != $past(used)) |-> (used == CNT_W'($past(used) + 1'b1)))
    else $error("entry count changed by other than one");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    !(match && miss))
    else $error("scan reported hit and miss together");

endmodule
`default_nettype wire

// ----- hw/rtl/access_rights_table.sv -----
// Top level of the access rights table: controller plus scan datapath.
// Each item (grant, deny, revoke or check on a 64-bit key) looks the key up
// by scanning the used entries in order through the single read port of the
// entry RAM, one entry per cycle while the scan is not paused, stopping at the
// first hit. Grant on an absent key appends an entry; a full table reports
// status 2, an absent key otherwise status 1. The result sits in an output
// register, so a new item is accepted while the previous result waits; the
// scan pauses while that register is still occupied.
`default_nettype none
module access_rights_table import acl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] key,
  input  wire logic [31:0] rights,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  status,
  output logic             granted
);

  acl_cmd_t cmd;
  acl_sts_t sts;

  acl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  acl_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .mode   (mode),
    .key    (key),
    .rights (rights),
    .status (status),
    .granted(granted)
  );

endmodule
`default_nettype wire
